/* src/pcg8br_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg8br_pkg: shared types and functions for the 8-bit PCG bounded generator
// LCG constants, RXS-M-XS permutation, controller states and command/status.
// ----------------------------------------------------------------------------
package pcg8br_pkg;

  localparam logic [7:0] LCG_MULT = 8'd141;
  localparam logic [7:0] RXS_XMUL = 8'd217;
  localparam logic [1:0] RXS_SH_BASE = 2'd2;
  localparam int unsigned RXS_OUT_SH = 6;

  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESEED,
    ST_THR,
    ST_TRY,
    ST_MOD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_draw;    // latch bound, start threshold remainder
    logic load_seed;    // first half of reseed
    logic reseed_step;  // final LCG step of reseed
    logic div_step;     // one remainder bit
    logic thr_save;     // keep remainder as rejection threshold
    logic try_step;     // permute + step LCG
    logic out_load;     // move remainder to result register
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic raw_ok;
    logic try_last;
  } status_t;

  // state * 141 + inc, mod 256
  function automatic logic [7:0] lcg_next(input logic [7:0] s, input logic [7:0] inc);
    logic [15:0] p;
    p = 16'(s) * 16'(LCG_MULT);
    return p[7:0] + inc;
  endfunction

  // RXS-M-XS output permutation
  function automatic logic [7:0] rxs_m_xs(input logic [7:0] s);
    logic [2:0]  sh;
    logic [7:0]  x;
    logic [15:0] p;
    logic [7:0]  w;
    sh = 3'(s[7:6]) + 3'(RXS_SH_BASE);
    x  = (s >> sh) ^ s;
    p  = 16'(x) * 16'(RXS_XMUL);
    w  = p[7:0];
    return (w >> RXS_OUT_SH) ^ w;
  endfunction

endpackage

/* src/pcg8_bounded_random.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg8_bounded_random: 8-bit PCG (RXS-M-XS) with unbiased bounded draws
// Reseed request: load the seed, then one LCG step; gives no result. Draw request:
// accept, threshold remainder one bit per step, rejection tries (usually one), final
// remainder, then load of the result register once it is free.
// The bit-serial remainder unit is used twice per draw.
// Synchronous reset: LCG state and increment cleared, controller idle.
// ----------------------------------------------------------------------------
module pcg8_bounded_random import pcg8br_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       op,
  input  logic [7:0] bound,
  input  logic [7:0] seed_state,
  input  logic [7:0] seed_sequence,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] value
);

  // controller <-> datapath
  cmd_t    cmd;
  status_t status;

  // Sequencer: one request in flight; a finished result sits in the
  // result register while the next request is taken.
  pcg8br_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: LCG, permutation, shared remainder unit, result register.
  // Bound 0 is held as 256, so the threshold is 0 and the raw value passes.
  pcg8br_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .bound         (bound),
    .seed_state    (seed_state),
    .seed_sequence (seed_sequence),
    .value         (value)
  );

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && result_stall))
    else $error("result register overwritten while stalled");

  // A result appears only from a result load.
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.out_load))
    else $error("result valid without result load");

  // While requests are taken, no work step is active.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> !(cmd.div_step || cmd.try_step || cmd.reseed_step))
    else $error("work step while accepting requests");

endmodule

/* src/pcg8br_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg8br_dp: datapath of the bounded generator
// LCG state, increment, bit-serial remainder unit, try counter, result reg.
// ----------------------------------------------------------------------------
module pcg8br_dp import pcg8br_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    status,
  input  logic [7:0] bound,
  input  logic [7:0] seed_state,
  input  logic [7:0] seed_sequence,
  output logic [7:0] value
);

  logic [7:0] lcg_state;
  logic [7:0] increment;
  logic [8:0] bound_b;     // 1..256
  logic [7:0] thr;
  logic [7:0] div_rem;
  logic [7:0] div_dvd;
  logic [2:0] bit_cnt;
  logic [7:0] try_cnt;

  logic [8:0] rem_sh;
  logic [7:0] div_rem_next;
  logic [7:0] raw;
  logic [7:0] seed_inc;

  assign seed_inc = {seed_sequence[6:0], 1'b1};
  assign raw      = rxs_m_xs(lcg_state);

  // restoring remainder, one dividend bit per step
  always_comb begin
    rem_sh = {div_rem, div_dvd[7]};
    if (rem_sh >= bound_b) begin
      div_rem_next = 8'(rem_sh - bound_b);
    end else begin
      div_rem_next = rem_sh[7:0];
    end
  end

  assign status.div_last = (bit_cnt == 3'd7);
  assign status.raw_ok   = (raw >= thr);
  assign status.try_last = (try_cnt == 8'hFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state <= 8'd0;
      increment <= 8'd0;
    end else begin
      if (cmd.load_seed) begin
        increment <= seed_inc;
        lcg_state <= seed_inc + seed_state;
      end
      if (cmd.reseed_step || cmd.try_step) begin
        lcg_state <= lcg_next(lcg_state, increment);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_draw) begin
      bound_b <= {(bound == 8'd0), bound};
      div_dvd <= (~bound) + 8'd1;   // (256 - b) mod 256
      div_rem <= 8'd0;
      bit_cnt <= 3'd0;
    end
    if (cmd.div_step) begin
      div_rem <= div_rem_next;
      div_dvd <= {div_dvd[6:0], 1'b0};
      bit_cnt <= bit_cnt + 3'd1;
    end
    if (cmd.thr_save) begin
      thr     <= div_rem_next;
      try_cnt <= 8'd0;
    end
    if (cmd.try_step) begin
      try_cnt <= try_cnt + 8'd1;
      if (status.raw_ok || status.try_last) begin
        div_dvd <= raw;
        div_rem <= 8'd0;
        bit_cnt <= 3'd0;
      end
    end
    if (cmd.out_load) begin
      value <= div_rem;
    end
  end

endmodule

/* src/pcg8br_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg8br_ctrl: sequencer of the bounded generator
// Steps reseed, threshold remainder, rejection tries, final remainder, result load.
// ----------------------------------------------------------------------------
module pcg8br_ctrl import pcg8br_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  logic    op,
  output logic    result_valid,
  input  logic    result_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (op == OP_RESEED) begin
            cmd.load_seed = 1'b1;
            state_next    = ST_RESEED;
          end else begin
            cmd.load_draw = 1'b1;
            state_next    = ST_THR;
          end
        end
      end
      ST_RESEED: begin
        cmd.reseed_step = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_THR: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.thr_save = 1'b1;
          state_next   = ST_TRY;
        end
      end
      ST_TRY: begin
        cmd.try_step = 1'b1;
        if (status.raw_ok || status.try_last) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    result_valid_next = cmd.out_load | (result_valid & result_stall);
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pcg8_bounded_random
// A short table of requests covers bound extremes, reseeds, the stuck
// generator after reset, then random draws and reseeds follow. Every result
// is compared against its typed value or an in-bench model of the PCG state and its
// rejection sampling; both handshakes idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import pcg8br_pkg::*;

  localparam int N_RANDOM    = 1450;
  localparam int CALM_TAIL   = 150;   // final random requests with no idling
  localparam int DRAIN_WAIT  = 300;   // covers a worst-case draw of 256 tries
  localparam int N_DIRECTED  = 22;
  localparam logic TYPED     = 1'b1;  // row carries its own expected value
  localparam logic PREDICTED = 1'b0;  // row is checked against the model

  // one directed request; packed so rows can be written as concatenations
  typedef struct packed {
    logic       op;
    logic [7:0] bound;
    logic [7:0] seed_st;
    logic [7:0] seed_seq;
    logic       typed;
    logic [7:0] want;
  } req_row_t;

  // DUT signals, all inputs known from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic       op = OP_DRAW;
  logic [7:0] bound = 8'd0;
  logic [7:0] seed_state = 8'd0;
  logic [7:0] seed_sequence = 8'd0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] value;

  // model state of the generator
  logic [7:0] gen_state = 8'd0;
  logic [7:0] gen_inc = 8'd0;

  logic [7:0] expected_values [$];
  logic [7:0] want_value;
  req_row_t   directed_rows [0:N_DIRECTED-1];

  logic       idle_on = 1'b1;
  int         stall_left = 0;
  int         n_draws = 0;
  int         n_reseeds = 0;
  int         n_results = 0;
  int         n_errors = 0;

  pcg8_bounded_random uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .bound        (bound),
    .seed_state   (seed_state),
    .seed_sequence(seed_sequence),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model of the generator
  // ---------------------------------------------------------------------------

  // LCG step: s * 141 + inc, mod 256
  function automatic logic [7:0] lcg_advance(input logic [7:0] s, input logic [7:0] inc);
    logic [15:0] prod;
    prod = 16'(s) * 16'd141;
    return prod[7:0] + inc;
  endfunction

  // RXS-M-XS: random xorshift by 2..5, multiply by 217, xorshift by 6
  function automatic logic [7:0] scramble(input logic [7:0] s);
    logic [7:0]  xs;
    logic [15:0] prod;
    logic [7:0]  w;
    xs   = (s >> (s[7:6] + 2)) ^ s;
    prod = 16'(xs) * 16'd217;
    w    = prod[7:0];
    return (w >> 6) ^ w;
  endfunction

  // Applies one request to the model; a draw returns its bounded value.
  task automatic model_request(input logic o, input logic [7:0] b, input logic [7:0] s,
                               input logic [7:0] q, output logic has_value,
                               output logic [7:0] v);
    int span;
    int floor_v;
    int raw;
    int tries;
    logic hit;
    has_value = 1'b0;
    v = 8'd0;
    if (o == OP_RESEED) begin
      // top bit of the sequence falls off; increment is always odd
      gen_inc   = {q[6:0], 1'b1};
      gen_state = lcg_advance(8'd0, gen_inc);
      gen_state = gen_state + s;
      gen_state = lcg_advance(gen_state, gen_inc);
    end else begin
      span    = (b == 8'd0) ? 256 : int'(b);
      floor_v = (256 - span) % span;
      raw     = 0;
      hit     = 1'b0;
      // give up after 256 tries; only reachable with an even increment
      for (tries = 0; tries < 256 && !hit; tries++) begin
        raw       = int'(scramble(gen_state));
        gen_state = lcg_advance(gen_state, gen_inc);
        hit       = (raw >= floor_v);
      end
      has_value = 1'b1;
      v = 8'(raw % span);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side: optional idle burst, then hold valid until accepted.
  // Acceptance is seen at the edge where valid is high and stall is low.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic o, input logic [7:0] b, input logic [7:0] s,
                              input logic [7:0] q);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    item_valid    <= 1'b1;
    op            <= o;
    bound         <= b;
    seed_state    <= s;
    seed_sequence <= q;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (o == OP_RESEED) n_reseeds++;
    else n_draws++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall in bursts of random length while idling is enabled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(0, 8);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Checker: each accepted result against the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      n_results++;
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d", $time, value);
        n_errors++;
      end else begin
        want_value = expected_values.pop_front();
        if (value !== want_value) begin
          $display("%0t: value mismatch, expected %0d, actual %0d",
                   $time, want_value, value);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic       has_value;
    logic [7:0] v;
    logic       r_op;
    logic [7:0] r_bound;
    logic [7:0] r_st;
    logic [7:0] r_seq;

    // Directed table. Right after reset the increment is zero and the state
    // sits at zero, so every raw output is zero: each early draw gives 0,
    // and a draw with a nonzero threshold exhausts all its tries.
    directed_rows = '{
      {OP_DRAW,   8'd0,   8'h00, 8'h00, TYPED,     8'd0},  // bound zero means 256
      {OP_DRAW,   8'd1,   8'h00, 8'h00, TYPED,     8'd0},
      {OP_DRAW,   8'd255, 8'h00, 8'h00, TYPED,     8'd0},  // stuck: tries run out
      {OP_DRAW,   8'd128, 8'h00, 8'h00, TYPED,     8'd0},
      {OP_DRAW,   8'd3,   8'hFF, 8'hFF, TYPED,     8'd0},  // seeds ignored on draw
      {OP_RESEED, 8'hAA,  8'h00, 8'h00, PREDICTED, 8'd0},  // bound ignored
      {OP_DRAW,   8'd0,   8'h00, 8'h00, PREDICTED, 8'd0},
      {OP_DRAW,   8'd255, 8'h00, 8'h00, PREDICTED, 8'd0},
      {OP_DRAW,   8'd1,   8'h00, 8'h00, TYPED,     8'd0},  // bound one is always 0
      {OP_RESEED, 8'h00,  8'hFF, 8'hFF, PREDICTED, 8'd0},  // seq top bit dropped
      {OP_DRAW,   8'd2,   8'h00, 8'h00, PREDICTED, 8'd0},
      {OP_DRAW,   8'd7,   8'h00, 8'h00, PREDICTED, 8'd0},
      {OP_DRAW,   8'd200, 8'h00, 8'h00, PREDICTED, 8'd0},
      {OP_DRAW,   8'd129, 8'h00, 8'h00, PREDICTED, 8'd0},
      {OP_RESEED, 8'h00,  8'h5A, 8'h7F, PREDICTED, 8'd0},  // back-to-back reseeds
      {OP_RESEED, 8'hFF,  8'hA5, 8'h80, PREDICTED, 8'd0},
      {OP_DRAW,   8'd100, 8'hFF, 8'hFF, PREDICTED, 8'd0},
      {OP_DRAW,   8'd0,   8'h00, 8'h00, PREDICTED, 8'd0},
      {OP_RESEED, 8'h00,  8'h00, 8'h80, PREDICTED, 8'd0},  // same inc as seq 0
      {OP_DRAW,   8'd255, 8'h00, 8'h00, PREDICTED, 8'd0},
      {OP_DRAW,   8'd128, 8'h00, 8'h00, PREDICTED, 8'd0},
      {OP_DRAW,   8'd1,   8'h00, 8'h00, TYPED,     8'd0}
    };

    // reset, applied once
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].bound,
                   directed_rows[i].seed_st, directed_rows[i].seed_seq);
      model_request(directed_rows[i].op, directed_rows[i].bound,
                    directed_rows[i].seed_st, directed_rows[i].seed_seq, has_value, v);
      if (has_value) expected_values.push_back(directed_rows[i].typed ?
                                               directed_rows[i].want : v);
    end

    // Random part: mostly draws, bound weighted toward the edges and small
    // values, with occasional reseeds. The tail runs with no idling.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - CALM_TAIL) idle_on <= 1'b0;
      r_op = ($urandom_range(0, 7) == 0) ? OP_RESEED : OP_DRAW;
      case ($urandom_range(0, 9))
        0: r_bound = 8'd0;
        1: r_bound = 8'd1;
        2: r_bound = 8'd255;
        3: r_bound = 8'($urandom_range(2, 16));
        4: r_bound = 8'd128 | 8'($urandom_range(0, 3));
        default: r_bound = 8'($urandom);
      endcase
      r_st  = 8'($urandom);
      r_seq = 8'($urandom);
      send_request(r_op, r_bound, r_st, r_seq);
      model_request(r_op, r_bound, r_st, r_seq, has_value, v);
      if (has_value) expected_values.push_back(v);
    end
    item_valid <= 1'b0;

    // drain, then watch for stray results
    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_values.size() != 0) begin
      $display("%0t: %0d results missing, expected none pending, actual %0d",
               $time, expected_values.size(), expected_values.size());
      n_errors++;
    end

    $display("Ran %0d draws and %0d reseeds; %0d results checked, %0d errors.",
             n_draws, n_reseeds, n_results, n_errors);
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* pcg8_bounded_random.f */
src/pcg8br_pkg.sv
src/pcg8br_dp.sv
src/pcg8br_ctrl.sv
src/pcg8_bounded_random.sv
sim/tb.sv
